/* rtl/rfc_pkg.sv */
package rfc_pkg;

  // slot pool geometry
  localparam int SLOTS_PER_TYPE = 2;
  localparam int NTYPES         = 3;
  localparam int QCW            = $clog2(SLOTS_PER_TYPE + 1);
  localparam int SIW            = (SLOTS_PER_TYPE > 1) ? $clog2(SLOTS_PER_TYPE) : 1;

  // descriptor buffer
  localparam int MAX_SEGS = 7;
  localparam int SEGW     = $clog2(MAX_SEGS + 1);

  typedef logic [QCW-1:0]            qcnt_t;
  typedef logic [SLOTS_PER_TYPE-1:0] srow_t;
  typedef logic [SIW-1:0]            sidx_t;

  // request kinds
  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_COMMIT  = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  // sub-packet types
  localparam logic [1:0] TYPE_STATUS = 2'd0;
  localparam logic [1:0] TYPE_HAPTIC = 2'd1;
  localparam logic [1:0] TYPE_AUDIO  = 2'd2;

  // segment kinds
  localparam logic [2:0] SEG_GRANT   = 3'd0;
  localparam logic [2:0] SEG_REFUSED = 3'd1;
  localparam logic [2:0] SEG_HEADER  = 3'd2;
  localparam logic [2:0] SEG_STATUS  = 3'd3;
  localparam logic [2:0] SEG_SETUP   = 3'd4;
  localparam logic [2:0] SEG_HAPTIC  = 3'd5;
  localparam logic [2:0] SEG_AUDIO   = 3'd6;
  localparam logic [2:0] SEG_PAD     = 3'd7;

  // sub-packet ids
  localparam logic [7:0] HAS_LEN_BIT = 8'h80;
  localparam logic [7:0] ID_STATUS   = 8'h10 | HAS_LEN_BIT;
  localparam logic [7:0] ID_SETUP    = 8'h11 | HAS_LEN_BIT;
  localparam logic [7:0] ID_HAPTIC   = 8'h12 | HAS_LEN_BIT;
  localparam logic [7:0] ID_SPEAKER  = 8'h13 | HAS_LEN_BIT;
  localparam logic [7:0] ID_HEADSET  = 8'h16 | HAS_LEN_BIT;

  // sub-packet length bytes
  localparam logic [7:0] LEN_STATUS = 8'd63;
  localparam logic [7:0] LEN_SETUP  = 8'd7;
  localparam logic [7:0] LEN_HAPTIC = 8'd64;
  localparam logic [7:0] LEN_AUDIO  = 8'd200;

  // segment sizes including the two head bytes
  localparam logic [9:0] HEAD_BYTES  = 10'd2;
  localparam logic [9:0] CRC_BYTES   = 10'd4;
  localparam logic [9:0] SEG_B_STAT  = HEAD_BYTES + 10'(LEN_STATUS);
  localparam logic [9:0] SEG_B_SETUP = HEAD_BYTES + 10'(LEN_SETUP);
  localparam logic [9:0] SEG_B_HAPT  = HEAD_BYTES + 10'(LEN_HAPTIC);
  localparam logic [9:0] SEG_B_AUDIO = HEAD_BYTES + 10'(LEN_AUDIO);

  // frame sizing
  localparam logic [9:0] FRAME_BASE     = 10'd78;
  localparam int         FRAME_STEP     = 64;
  localparam int         FRAME_IDS      = 8;
  localparam logic [9:0] FRAME_MAX      = 10'd547;
  localparam logic [9:0] EXTRA_LIMIT    = FRAME_MAX - SEG_B_AUDIO;
  localparam logic [7:0] REPORT_ID_BASE = 8'h31;
  localparam logic [7:0] REPORT_ID_FULL = 8'h39;

  // configuration
  localparam int         CFG_IW            = 2;
  localparam int         CFG_DW            = 8;
  localparam logic [1:0] CFG_AUDIO_ACTIVE  = 2'd0;
  localparam logic [1:0] CFG_HEADSET       = 2'd1;
  localparam logic [1:0] CFG_AUDIO_BUF_LEN = 2'd2;

  typedef struct packed {
    logic [2:0] seg_kind;
    logic       slot_out;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [9:0] offset;
    logic [9:0] seg_length;
    logic [9:0] frame_size;
    logic [7:0] setup_counter;
  } desc_t;

endpackage

/* rtl/rfc_cmd_if.sv */
interface rfc_cmd_if import rfc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [1:0] sub_type;
  logic       slot;

  modport source (output valid, output kind, output sub_type, output slot, input ready);
  modport sink (input valid, input kind, input sub_type, input slot, output ready);
endinterface

/* rtl/rfc_seg_if.sv */
interface rfc_seg_if import rfc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] seg_kind;
  logic       slot_out;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [9:0] offset;
  logic [9:0] seg_length;
  logic [9:0] frame_size;
  logic [7:0] setup_counter;
  logic       last;

  modport source (
    output valid, output seg_kind, output slot_out, output first_byte, output second_byte,
    output offset, output seg_length, output frame_size, output setup_counter, output last,
    input ready
  );
  modport sink (
    input valid, input seg_kind, input slot_out, input first_byte, input second_byte,
    input offset, input seg_length, input frame_size, input setup_counter, input last,
    output ready
  );
endinterface

/* rtl/report_frame_composer_top.sv */
// channel   dir  word                                 notes
// cmd       in   kind, sub_type, slot                 valid/ready, one request per word
// seg       out  descriptor fields + last             valid/ready, 0..7 words per request
// cfg       in   cfg_write, cfg_index, cfg_data       plain write, no back-pressure
//
// a request waits in the input register until the buffer is empty or its final word leaves,
// then its whole effect on the slot pool and queues is worked out in one pass and lands in a
// seven-entry descriptor buffer; the buffer drains one word per cycle while the sink is ready,
// and the drain of the descriptor buffer sets the rate
// a request producing no words retires in its processing cycle
// rst is synchronous and clears pool, queue counts, counters and flags, not stored entries
// an empty input register takes a new word while descriptors still wait on a stalled sink
module report_frame_composer_top import rfc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  rfc_cmd_if.sink           cmd,
  rfc_seg_if.source         seg,
  input  logic              cfg_write,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  // configuration registers
  logic audio_active;
  logic headset_plugged;

  // input register
  logic       in_full;
  logic [1:0] in_kind;
  logic [1:0] in_type;
  logic       in_slot;

  // slot pool and per-type queues
  srow_t busy [NTYPES];
  srow_t qent [NTYPES];
  qcnt_t qcnt [NTYPES];
  logic [3:0] seq;
  logic [7:0] setup_cnt;

  srow_t      busy_next [NTYPES];
  srow_t      qent_next [NTYPES];
  qcnt_t      qcnt_next [NTYPES];
  logic [3:0] seq_next;
  logic [7:0] setup_cnt_next;

  // descriptor buffer, doubles as the output register
  desc_t           desc [MAX_SEGS];
  desc_t           desc_next [MAX_SEGS];
  logic [SEGW-1:0] seg_count;
  logic [SEGW-1:0] seg_count_next;
  logic [SEGW-1:0] seg_idx;

  logic seg_take;
  logic seg_is_last;
  logic process;

  // read entry i of a queue row, zero past the end
  function automatic logic ent(srow_t row, int i);
    logic r;
    r = 1'b0;
    if (i < SLOTS_PER_TYPE) r = row[sidx_t'(i)];
    return r;
  endfunction

  // drop k entries from the head of a queue row
  function automatic srow_t pop_row(srow_t row, int k);
    srow_t r;
    r = row;
    for (int i = 0; i < SLOTS_PER_TYPE; i++) begin
      if (i + k < SLOTS_PER_TYPE) r[sidx_t'(i)] = row[sidx_t'(i + k)];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------------------
  assign seg_is_last = (seg_idx == seg_count - 1'b1);
  assign seg_take    = seg.valid && seg.ready;
  // the request is worked once the buffer is empty or its final word leaves now
  assign process     = in_full && ((seg_count == '0) || (seg_take && seg_is_last));
  assign cmd.ready   = !in_full || process;

  assign seg.valid         = (seg_count != '0);
  assign seg.seg_kind      = desc[seg_idx].seg_kind;
  assign seg.slot_out      = desc[seg_idx].slot_out;
  assign seg.first_byte    = desc[seg_idx].first_byte;
  assign seg.second_byte   = desc[seg_idx].second_byte;
  assign seg.offset        = desc[seg_idx].offset;
  assign seg.seg_length    = desc[seg_idx].seg_length;
  assign seg.frame_size    = desc[seg_idx].frame_size;
  assign seg.setup_counter = desc[seg_idx].setup_counter;
  assign seg.last          = seg_is_last;

  // ---------------------------------------------------------------------------------------
  // single pass over one request
  // ---------------------------------------------------------------------------------------
  always_comb begin
    logic            found;
    sidx_t           gslot;
    qcnt_t           h;
    qcnt_t           a;
    qcnt_t           st;
    logic [1:0]      nh;
    logic [1:0]      na;
    logic            ns;
    logic            due;
    logic            frame;
    logic            has_sub;
    logic            done_k;
    logic [9:0]      size;
    logic [9:0]      fs;
    logic [9:0]      off;
    logic [7:0]      rid;
    logic [1:0]      hslot;
    logic [1:0]      aslot;
    logic            sslot;
    logic [SEGW-1:0] n;

    for (int t = 0; t < NTYPES; t++) begin
      busy_next[t] = busy[t];
      qent_next[t] = qent[t];
      qcnt_next[t] = qcnt[t];
    end
    seq_next       = seq;
    setup_cnt_next = setup_cnt;
    for (int i = 0; i < MAX_SEGS; i++) desc_next[i] = '0;
    n       = '0;
    found   = 1'b0;
    gslot   = '0;
    h       = '0;
    a       = '0;
    st      = '0;
    nh      = '0;
    na      = '0;
    ns      = 1'b0;
    due     = 1'b0;
    frame   = 1'b0;
    has_sub = 1'b0;
    done_k  = 1'b0;
    size    = '0;
    fs      = FRAME_MAX;
    off     = '0;
    rid     = REPORT_ID_FULL;
    hslot   = '0;
    aslot   = '0;
    sslot   = 1'b0;

    unique case (in_kind)
      KIND_ALLOC: begin
        if (int'(in_type) < NTYPES) begin
          for (int i = 0; i < SLOTS_PER_TYPE; i++) begin
            if (!found && !busy_next[in_type][sidx_t'(i)]) begin
              found = 1'b1;
              gslot = sidx_t'(i);
            end
          end
          // pool exhausted: flush the type's queue, then retry
          if (!found) begin
            for (int i = 0; i < SLOTS_PER_TYPE; i++) begin
              if (QCW'(i) < qcnt_next[in_type]) begin
                busy_next[in_type][sidx_t'(ent(qent_next[in_type], i))] = 1'b0;
              end
            end
            qcnt_next[in_type] = '0;
            for (int i = 0; i < SLOTS_PER_TYPE; i++) begin
              if (!found && !busy_next[in_type][sidx_t'(i)]) begin
                found = 1'b1;
                gslot = sidx_t'(i);
              end
            end
          end
          if (found) busy_next[in_type][gslot] = 1'b1;
        end
        desc_next[0].seg_kind = found ? SEG_GRANT : SEG_REFUSED;
        desc_next[0].slot_out = found ? 1'(gslot) : 1'b0;
        n = SEGW'(1);
      end
      KIND_COMMIT: begin
        if (int'(in_type) < NTYPES && int'(in_slot) < SLOTS_PER_TYPE) begin
          // push, dropped when full
          if (int'(qcnt_next[in_type]) < SLOTS_PER_TYPE) begin
            qent_next[in_type][qcnt_next[in_type][SIW-1:0]] = in_slot;
            qcnt_next[in_type] = qcnt_next[in_type] + 1'b1;
          end

          h  = qcnt_next[TYPE_HAPTIC];
          a  = qcnt_next[TYPE_AUDIO];
          st = qcnt_next[TYPE_STATUS];
          if (audio_active) due = (h != '0 && a != '0) || (h > QCW'(1)) || (a > QCW'(1));
          else              due = (h != '0) || (a != '0) || (st != '0);

          if (due) begin
            nh = (h > QCW'(1)) ? 2'd2 : 2'(h);
            if (a != '0) begin
              na = 2'd1;
              if (nh == 2'd0 && a > QCW'(1)) na = 2'd2;
            end
            size    = 10'(nh) * SEG_B_HAPT + 10'(na) * SEG_B_AUDIO;
            has_sub = (size != '0);
            if (has_sub) size = size + SEG_B_SETUP;
            if (!(audio_active && !has_sub)) begin
              ns   = (st != '0);
              size = size + (ns ? SEG_B_STAT : 10'd0);
              if (size != '0) begin
                frame = 1'b1;
                size  = size + HEAD_BYTES + CRC_BYTES;
                // room left for one more audio sub-packet
                if (size < EXTRA_LIMIT && na < 2'd2 && int'(a) > int'(na)) begin
                  na   = na + 2'd1;
                  size = size + SEG_B_AUDIO;
                end
              end
            end
          end

          if (frame) begin
            hslot = {ent(qent_next[TYPE_HAPTIC], 1), ent(qent_next[TYPE_HAPTIC], 0)};
            aslot = {ent(qent_next[TYPE_AUDIO], 1), ent(qent_next[TYPE_AUDIO], 0)};
            sslot = ent(qent_next[TYPE_STATUS], 0);

            for (int k = 0; k < FRAME_IDS; k++) begin
              if (!done_k && size <= FRAME_BASE + 10'(FRAME_STEP * k)) begin
                done_k = 1'b1;
                fs     = FRAME_BASE + 10'(FRAME_STEP * k);
                rid    = REPORT_ID_BASE + 8'(k);
              end
            end

            desc_next[n] = '{SEG_HEADER, 1'b0, rid, {seq, 4'b0000}, 10'd0, HEAD_BYTES, fs,
                             8'd0};
            n        = n + 1'b1;
            seq_next = seq + 1'b1;
            off      = HEAD_BYTES;
            if (ns) begin
              desc_next[n] = '{SEG_STATUS, sslot, ID_STATUS, LEN_STATUS, off, SEG_B_STAT, fs,
                               8'd0};
              n   = n + 1'b1;
              off = off + SEG_B_STAT;
            end
            if (nh != 2'd0 || na != 2'd0) begin
              desc_next[n] = '{SEG_SETUP, 1'b0, ID_SETUP, LEN_SETUP, off, SEG_B_SETUP, fs,
                               setup_cnt};
              n              = n + 1'b1;
              setup_cnt_next = setup_cnt + 1'b1;
              off            = off + SEG_B_SETUP;
            end
            for (int j = 0; j < 2; j++) begin
              if (2'(j) < nh) begin
                desc_next[n] = '{SEG_HAPTIC, hslot[j], ID_HAPTIC, LEN_HAPTIC, off, SEG_B_HAPT,
                                 fs, 8'd0};
                n   = n + 1'b1;
                off = off + SEG_B_HAPT;
                busy_next[TYPE_HAPTIC][sidx_t'(hslot[j])] = 1'b0;
              end
            end
            for (int j = 0; j < 2; j++) begin
              if (2'(j) < na) begin
                desc_next[n] = '{SEG_AUDIO, aslot[j],
                                 headset_plugged ? ID_HEADSET : ID_SPEAKER, LEN_AUDIO, off,
                                 SEG_B_AUDIO, fs, 8'd0};
                n   = n + 1'b1;
                off = off + SEG_B_AUDIO;
                busy_next[TYPE_AUDIO][sidx_t'(aslot[j])] = 1'b0;
              end
            end
            desc_next[n] = '{SEG_PAD, 1'b0, 8'd0, 8'd0, off, (off < fs) ? fs - off : 10'd0,
                             fs, 8'd0};
            n = n + 1'b1;
            if (ns) busy_next[TYPE_STATUS][sidx_t'(sslot)] = 1'b0;

            // retire popped entries
            qent_next[TYPE_HAPTIC] = pop_row(qent_next[TYPE_HAPTIC], int'(nh));
            qent_next[TYPE_AUDIO]  = pop_row(qent_next[TYPE_AUDIO], int'(na));
            qent_next[TYPE_STATUS] = pop_row(qent_next[TYPE_STATUS], int'(ns));
            qcnt_next[TYPE_HAPTIC] = qcnt_next[TYPE_HAPTIC] - QCW'(nh);
            qcnt_next[TYPE_AUDIO]  = qcnt_next[TYPE_AUDIO] - QCW'(na);
            qcnt_next[TYPE_STATUS] = qcnt_next[TYPE_STATUS] - QCW'(ns);
          end
        end
      end
      KIND_RELEASE: begin
        if (int'(in_type) < NTYPES && int'(in_slot) < SLOTS_PER_TYPE) begin
          busy_next[in_type][sidx_t'(in_slot)] = 1'b0;
        end
      end
      default: begin
        // unused kind code, no effect
      end
    endcase
    seg_count_next = n;
  end

  // ---------------------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      audio_active    <= 1'b0;
      headset_plugged <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_AUDIO_ACTIVE:  audio_active    <= cfg_data[0];
        CFG_HEADSET:       headset_plugged <= cfg_data[0];
        CFG_AUDIO_BUF_LEN: begin
          // setup content byte, consumed by the payload path only
        end
        default: begin
          // no register here
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_kind <= cmd.kind;
      in_type <= cmd.sub_type;
      in_slot <= cmd.slot;
    end
    if (process) desc <= desc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      seg_count <= '0;
      seg_idx   <= '0;
      seq       <= '0;
      setup_cnt <= '0;
      for (int t = 0; t < NTYPES; t++) begin
        busy[t] <= '0;
        qcnt[t] <= '0;
      end
    end else begin
      if (cmd.valid && cmd.ready) in_full <= 1'b1;
      else if (process)           in_full <= 1'b0;

      if (process) begin
        seg_count <= seg_count_next;
        seg_idx   <= '0;
        seq       <= seq_next;
        setup_cnt <= setup_cnt_next;
        busy      <= busy_next;
        qcnt      <= qcnt_next;
      end else if (seg_take) begin
        if (seg_is_last) begin
          seg_count <= '0;
          seg_idx   <= '0;
        end else begin
          seg_idx <= seg_idx + 1'b1;
        end
      end
    end
  end

  // queue entries carry no reset, only entries below the count are ever read
  always_ff @(posedge clk) begin
    if (process) qent <= qent_next;
  end

  // ---------------------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------------------
  a_idx_in_range : assert property (@(posedge clk) disable iff (rst)
    seg.valid |-> seg_idx < seg_count)
    else $error("descriptor index past buffer fill");

  a_queue_bound : assert property (@(posedge clk) disable iff (rst)
    int'(qcnt[TYPE_STATUS]) <= SLOTS_PER_TYPE && int'(qcnt[TYPE_HAPTIC]) <= SLOTS_PER_TYPE &&
    int'(qcnt[TYPE_AUDIO]) <= SLOTS_PER_TYPE)
    else $error("queue count beyond slot count");

  a_pad_is_last : assert property (@(posedge clk) disable iff (rst)
    seg.valid && seg.seg_kind == SEG_PAD |-> seg.last)
    else $error("pad segment not final word");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    seg.valid && !seg.ready |=> seg.valid && $stable(seg_idx))
    else $error("descriptor moved under stall");

  a_header_first : assert property (@(posedge clk) disable iff (rst)
    seg.valid && seg_idx != '0 |-> desc[0].seg_kind == SEG_HEADER)
    else $error("multi-word burst without leading header");

endmodule
